/* hw/rtl/mcas_pkg.sv */
// Shared types, constants and helpers for the minimum-cost assignment solver.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mcas_pkg;

   // Field widths fixed by the channel formats.
   localparam int IDX_BITS      = 4;
   localparam int COST_IN_BITS  = 16;
   localparam int SIZE_BITS     = 5;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_SIZE  = 16;
   localparam int DEF_COST_BITS = 16;

   // Largest run of results one solve may report.
   localparam int RESULT_CAP    = 16;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(16);
   localparam logic signed [31:0]   SLACK_INF  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]   SLACK_MIN  = 32'sh8000_0000;

   typedef struct packed {
      logic [IDX_BITS-1:0]            row_index;
      logic [IDX_BITS-1:0]            col_index;
      logic signed [COST_IN_BITS-1:0] cost;
      logic                           last;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] result_index;
      logic [IDX_BITS-1:0] col_of_row;
      logic [IDX_BITS-1:0] row_of_col;
      logic                last_out;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_ROW,
      S_PICK,
      S_RD,
      S_EX,
      S_UPD,
      S_CHK,
      S_AUG,
      S_MAPCLR,
      S_MAP,
      S_EMIT
   } state_type;

   // Clamp a 34-bit sum into the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] res;
      if (v > 34'sh0_7FFF_FFFF) begin
         res = SLACK_INF;
      end else if (v < -34'sh0_8000_0000) begin
         res = SLACK_MIN;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/mcas_cost_mem.sv */
// Cost matrix store: one write port, one read port, registered read data.
// Depends on mcas_pkg for the default depth and cost width.
`default_nettype none

module mcas_cost_mem
   import mcas_pkg::*;
#(
   parameter int DEPTH     = DEF_MAX_SIZE * DEF_MAX_SIZE,
   parameter int COST_BITS = DEF_COST_BITS,
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [COST_BITS-1:0] wr_data,
   input  wire logic [AW-1:0]        rd_addr,
   output logic      [COST_BITS-1:0] rd_data
);

   logic [COST_BITS-1:0] mem [0:DEPTH-1];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/mcas_engine.sv */
// Solve sequencer: potentials, slack and matching held in small register files,
// costs read from the cost store. Depends on mcas_pkg.
`default_nettype none

module mcas_engine
   import mcas_pkg::*;
#(
   parameter int MAX_SIZE  = DEF_MAX_SIZE,
   parameter int COST_BITS = DEF_COST_BITS,
   localparam int SW       = $clog2(MAX_SIZE + 1),
   localparam int CW       = SW + 1,
   localparam int AW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [SW-1:0]        size_in,
   output logic      [AW-1:0]        rd_addr,
   input  wire logic [COST_BITS-1:0] rd_data,
   output logic                      res_valid,
   input  wire logic                 res_ready,
   output rsp_payload_type           res_data,
   output logic                      idle
);

   state_type state_ff, state_in;

   logic [SW-1:0] n_ff, c_ff, cur_ff, next_ff, osel_ff, k_ff;
   logic [CW-1:0] r_ff, guard_ff;
   logic signed [31:0] rp_ff, best_ff;

   logic signed [31:0] rowpot_ff [0:MAX_SIZE];
   logic signed [31:0] colpot_ff [0:MAX_SIZE];
   logic signed [31:0] slack_ff  [0:MAX_SIZE];
   logic [SW-1:0]      owner_ff  [0:MAX_SIZE];
   logic [SW-1:0]      link_ff   [0:MAX_SIZE];
   logic [SW-1:0]      r2c_ff    [0:MAX_SIZE];
   logic               seen_ff   [0:MAX_SIZE];

   logic signed [31:0] diff, ms;
   logic [SW-1:0]      pick_o, upd_o, aug_prev, map_o, k_next;
   logic               last_col, aug_go, chk_go;

   // Combinational helpers shared by the state machine and the datapath.
   always_comb begin
      diff = sat32(34'(signed'(rd_data)) - 34'(rp_ff) - 34'(colpot_ff[c_ff]));
      ms   = (diff < slack_ff[c_ff]) ? diff : slack_ff[c_ff];
      pick_o = owner_ff[cur_ff];
      if (pick_o == '0 || pick_o > n_ff) begin
         pick_o = SW'(1);
      end
      upd_o    = owner_ff[c_ff];
      aug_prev = link_ff[cur_ff];
      if (aug_prev > n_ff) begin
         aug_prev = '0;
      end
      map_o    = owner_ff[c_ff];
      k_next   = k_ff + SW'(1);
      last_col = (c_ff == n_ff);
      aug_go   = (cur_ff != '0) && (guard_ff <= CW'(n_ff));
      chk_go   = (owner_ff[cur_ff] != '0) && (cur_ff != '0) && (guard_ff <= CW'(n_ff));
      rd_addr  = AW'((32'(osel_ff) - 32'd1) * MAX_SIZE + 32'(c_ff) - 32'd1);
   end

   // Next state and handshake outputs.
   always_comb begin
      state_in  = state_ff;
      idle      = 1'b0;
      res_valid = 1'b0;
      res_data.result_index = IDX_BITS'(k_ff);
      res_data.col_of_row   = IDX_BITS'(r2c_ff[k_ff]);
      res_data.row_of_col   = (owner_ff[k_next] != '0) ?
                              IDX_BITS'(owner_ff[k_next] - SW'(1)) : '0;
      res_data.last_out     = (k_next == n_ff);
      unique case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (start) state_in = S_INIT;
         end
         S_INIT:   state_in = S_ROW;
         S_ROW:    state_in = S_PICK;
         S_PICK:   state_in = S_RD;
         S_RD:     state_in = S_EX;
         S_EX:     state_in = last_col ? S_UPD : S_RD;
         S_UPD:    state_in = last_col ? S_CHK : S_UPD;
         S_CHK:    state_in = chk_go ? S_PICK : S_AUG;
         S_AUG: begin
            if (!aug_go) begin
               state_in = (r_ff == CW'(n_ff)) ? S_MAPCLR : S_ROW;
            end
         end
         S_MAPCLR: state_in = S_MAP;
         S_MAP:    state_in = last_col ? S_EMIT : S_MAP;
         S_EMIT: begin
            res_valid = 1'b1;
            if (res_ready && k_next == n_ff) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath: read, modify and write back the register files.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            n_ff <= size_in;
         end
         S_INIT: begin
            for (int i = 0; i <= MAX_SIZE; i++) begin
               rowpot_ff[i] <= '0;
               colpot_ff[i] <= '0;
               owner_ff[i]  <= '0;
               link_ff[i]   <= '0;
            end
            r_ff <= CW'(1);
         end
         S_ROW: begin
            owner_ff[0] <= SW'(r_ff);
            for (int i = 0; i <= MAX_SIZE; i++) begin
               slack_ff[i] <= SLACK_INF;
               seen_ff[i]  <= 1'b0;
            end
            cur_ff   <= '0;
            guard_ff <= '0;
         end
         S_PICK: begin
            seen_ff[cur_ff] <= 1'b1;
            osel_ff <= pick_o;
            rp_ff   <= rowpot_ff[pick_o];
            best_ff <= SLACK_INF;
            next_ff <= '0;
            c_ff    <= SW'(1);
         end
         S_RD: begin
         end
         S_EX: begin
            if (!seen_ff[c_ff]) begin
               if (diff < slack_ff[c_ff]) begin
                  slack_ff[c_ff] <= diff;
                  link_ff[c_ff]  <= cur_ff;
               end
               if (ms < best_ff) begin
                  best_ff <= ms;
                  next_ff <= c_ff;
               end
            end
            c_ff <= last_col ? '0 : c_ff + SW'(1);
         end
         S_UPD: begin
            if (seen_ff[c_ff]) begin
               if (upd_o <= n_ff) begin
                  rowpot_ff[upd_o] <= sat32(34'(rowpot_ff[upd_o]) + 34'(best_ff));
               end
               colpot_ff[c_ff] <= sat32(34'(colpot_ff[c_ff]) - 34'(best_ff));
            end else begin
               slack_ff[c_ff] <= sat32(34'(slack_ff[c_ff]) - 34'(best_ff));
            end
            if (last_col) begin
               cur_ff   <= next_ff;
               guard_ff <= guard_ff + CW'(1);
            end else begin
               c_ff <= c_ff + SW'(1);
            end
         end
         S_CHK: begin
            if (!chk_go) guard_ff <= '0;
         end
         S_AUG: begin
            if (aug_go) begin
               owner_ff[cur_ff] <= owner_ff[aug_prev];
               cur_ff   <= aug_prev;
               guard_ff <= guard_ff + CW'(1);
            end else begin
               r_ff <= r_ff + CW'(1);
            end
         end
         S_MAPCLR: begin
            for (int i = 0; i <= MAX_SIZE; i++) begin
               r2c_ff[i] <= '0;
            end
            c_ff <= SW'(1);
         end
         S_MAP: begin
            if (map_o != '0 && map_o <= n_ff) begin
               r2c_ff[map_o - SW'(1)] <= c_ff - SW'(1);
            end
            if (last_col) begin
               k_ff <= '0;
            end else begin
               c_ff <= c_ff + SW'(1);
            end
         end
         S_EMIT: begin
            if (res_ready) k_ff <= k_next;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/min_cost_assignment_solver_core.sv */
// Top level of the minimum-cost assignment solver: size register, load path,
// result register. Depends on mcas_pkg, mcas_cost_mem and mcas_engine.
//
//   channel | ports           | beat
//   --------+-----------------+-------------------------------------------
//   input   | req_valid/ready | one cost entry, row/column/cost/last
//   result  | rsp_valid/ready | one index k: column of row k, row of col k
//   config  | csr_wr_en/data  | matrix size n
//
// Loading accepts one entry per cycle while the engine is idle. A beat marked
// last starts the solve: for each of the n rows, augmenting steps that each
// read the cost store per column and then sweep a potential update, at most
// n+1 steps per row; then a mapping pass over the columns and n result
// beats. Input is refused from the start of the solve until the last result
// has entered the output register. Reset is synchronous.
`default_nettype none

module min_cost_assignment_solver_core
   import mcas_pkg::*;
#(
   parameter int MAX_SIZE  = DEF_MAX_SIZE,
   parameter int COST_BITS = DEF_COST_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_payload_type      req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  wire logic                 csr_wr_en,
   input  wire logic [SIZE_BITS-1:0] csr_wr_data
);

   localparam int SW    = $clog2(MAX_SIZE + 1);
   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIM   = (MAX_SIZE < RESULT_CAP) ? MAX_SIZE : RESULT_CAP;

   logic [SIZE_BITS-1:0] size_ff;
   logic [SW-1:0]        size_use;
   logic                 accept, wr_en, idle, res_valid, res_ready;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [COST_BITS-1:0] rd_data;
   rsp_payload_type      res_data;
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_data_ff;

   // Size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // Size in use: zero reads as one, large values saturate.
   always_comb begin
      if (size_ff == '0) begin
         size_use = SW'(1);
      end else if (32'(size_ff) > LIM) begin
         size_use = SW'(LIM);
      end else begin
         size_use = SW'(size_ff);
      end
   end

   // Load path into the cost store.
   assign req_ready = idle;
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (32'(req_payload.row_index) < MAX_SIZE) &&
                      (32'(req_payload.col_index) < MAX_SIZE);
   assign wr_addr   = AW'(32'(req_payload.row_index) * MAX_SIZE +
                          32'(req_payload.col_index));

   mcas_cost_mem #(
      .DEPTH     (DEPTH),
      .COST_BITS (COST_BITS)
   ) u_cost_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (COST_BITS'(unsigned'(req_payload.cost))),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mcas_engine #(
      .MAX_SIZE  (MAX_SIZE),
      .COST_BITS (COST_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && req_payload.last),
      .size_in   (size_use),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .idle      (idle)
   );

   // Result register.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench for the minimum-cost assignment solver: loads cost matrices, runs solves and
// checks every reported assignment against an in-bench Hungarian-method predictor.
// Depends on mcas_pkg and min_cost_assignment_solver_core.
`default_nettype none

module tb;
   import mcas_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_payload;
   logic csr_wr_en;
   logic [SIZE_BITS-1:0] csr_wr_data;

   // Predictor state: the stored matrix and the size register as the block sees them.
   logic signed [31:0] cost_mirror [0:255];
   logic [SIZE_BITS-1:0] size_reg;
   rsp_payload_type expected_assignments [$];

   int error_count;
   int beats_sent;
   int solves_run;
   int results_seen;
   int cycle_count;
   int hold_off_cycles;
   bit burst_on;
   int burst_left;

   min_cost_assignment_solver_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      logic signed [31:0] res;
      if (v > 64'sd2147483647) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         res = 32'sh8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   // Potential-based Hungarian solve over the mirrored matrix; queues n assignments.
   task automatic predict_assignments();
      logic signed [31:0] u [0:16];
      logic signed [31:0] v [0:16];
      logic signed [31:0] slack [0:16];
      int owner_of [0:16];
      int link [0:16];
      bit visited [0:16];
      int col_for_row [0:15];
      int n, cur, guard, owner, next, prev, o;
      logic signed [31:0] best, diff;
      rsp_payload_type item;
      n = (size_reg < 1) ? 1 : ((size_reg > 16) ? 16 : int'(size_reg));
      for (int i = 0; i <= 16; i++) begin
         u[i] = 0; v[i] = 0; owner_of[i] = 0; link[i] = 0;
      end
      for (int r = 1; r <= n; r++) begin
         cur = 0;
         guard = 0;
         owner_of[0] = r;
         for (int c = 0; c <= n; c++) begin
            slack[c] = SLACK_INF;
            visited[c] = 1'b0;
         end
         do begin
            next = 0;
            best = SLACK_INF;
            visited[cur] = 1'b1;
            owner = owner_of[cur];
            if (owner < 1 || owner > n) owner = 1;
            for (int c = 1; c <= n; c++) begin
               if (!visited[c]) begin
                  diff = clamp32(64'(cost_mirror[(owner - 1) * 16 + c - 1]) - 64'(u[owner])
                                 - 64'(v[c]));
                  if (diff < slack[c]) begin
                     slack[c] = diff;
                     link[c] = cur;
                  end
                  if (slack[c] < best) begin
                     best = slack[c];
                     next = c;
                  end
               end
            end
            for (int c = 0; c <= n; c++) begin
               if (visited[c]) begin
                  o = owner_of[c];
                  if (o <= n) u[o] = clamp32(64'(u[o]) + 64'(best));
                  v[c] = clamp32(64'(v[c]) - 64'(best));
               end else begin
                  slack[c] = clamp32(64'(slack[c]) - 64'(best));
               end
            end
            cur = next;
            guard++;
         end while (owner_of[cur] != 0 && cur != 0 && guard <= n);
         guard = 0;
         while (cur != 0 && guard <= n) begin
            prev = link[cur];
            if (prev > n) prev = 0;
            owner_of[cur] = owner_of[prev];
            cur = prev;
            guard++;
         end
      end
      for (int k = 0; k < 16; k++) col_for_row[k] = 0;
      for (int c = 1; c <= n; c++) begin
         o = owner_of[c];
         if (o >= 1 && o <= n) col_for_row[o - 1] = c - 1;
      end
      for (int k = 0; k < n; k++) begin
         o = owner_of[k + 1];
         item.result_index = 4'(k);
         item.col_of_row = 4'(col_for_row[k]);
         item.row_of_col = 4'((o >= 1) ? o - 1 : 0);
         item.last_out = (k + 1 == n);
         expected_assignments.push_back(item);
      end
      solves_run++;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // Sends one entry beat; in burst mode, bursts of random length with random gaps between them.
   task automatic send_entry(input int row, input int col, input int cost, input bit last);
      if (burst_on && burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_payload.row_index = 4'(row);
      req_payload.col_index = 4'(col);
      req_payload.cost = 16'(cost);
      req_payload.last = last;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      cost_mirror[row * 16 + col] = 32'(signed'(16'(cost)));
      beats_sent++;
      if (burst_left > 0) burst_left--;
      if (last) predict_assignments();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_assignments.size() != 0) @(negedge clock);
   endtask

   task automatic write_size(input int n);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= SIZE_BITS'(n);
      size_reg = SIZE_BITS'(n);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Loads the full n-by-n matrix with costs from a chosen range, last on the final entry.
   task automatic load_matrix(input int n, input int lo, input int hi);
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            send_entry(r, c, $urandom_range(hi - lo, 0) + lo, (r == n - 1) && (c == n - 1));
         end
      end
   endtask

   // Extremes: size one, size zero, most negative and positive costs, ties.
   task automatic test_directed();
      write_size(1);
      send_entry(0, 0, -32768, 1'b1);
      send_entry(0, 0, 32767, 1'b1);
      write_size(0);
      send_entry(15, 15, 5, 1'b0);
      send_entry(0, 0, 1, 1'b1);
      write_size(2);
      send_entry(0, 0, 7, 1'b0);
      send_entry(0, 1, 7, 1'b0);
      send_entry(1, 0, 7, 1'b0);
      send_entry(1, 1, 7, 1'b1);
      send_entry(0, 1, -32768, 1'b0);
      send_entry(1, 0, 32767, 1'b1);
      write_size(3);
      load_matrix(3, 32000, 32767);
   endtask

   // Largest size with full-range costs, then a saturated size register.
   task automatic test_full_size();
      write_size(16);
      load_matrix(16, -32768, 32767);
      write_size(31);
      send_entry(3, 9, -1, 1'b1);
   endtask

   // Random small matrices with stray entries outside n mixed in.
   task automatic test_random();
      int n;
      burst_on = 1'b1;
      while (beats_sent < 300) begin
         n = $urandom_range(2, 5);
         write_size(n);
         load_matrix(n, -32768, 32767);
         if ($urandom_range(0, 2) == 0) begin
            send_entry($urandom_range(15, n), $urandom_range(15, 0), $urandom, 1'b0);
            send_entry(0, 0, $urandom, 1'b1);
         end
      end
      burst_on = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering; the input must stall.
   task automatic test_backpressure();
      write_size(2);
      hold_off_cycles = 400;
      load_matrix(2, -100, 100);
      load_matrix(2, -100, 100);
      wait_drained();
   endtask

   // Result checking at each accepted result beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_assignments.size() == 0) begin
            report_mismatch("unexpected result index", rsp_payload.result_index, -1);
         end else begin
            rsp_payload_type want;
            want = expected_assignments.pop_front();
            if (rsp_payload.result_index !== want.result_index)
               report_mismatch("result_index", rsp_payload.result_index, want.result_index);
            if (rsp_payload.col_of_row !== want.col_of_row)
               report_mismatch("col_of_row", rsp_payload.col_of_row, want.col_of_row);
            if (rsp_payload.row_of_col !== want.row_of_col)
               report_mismatch("row_of_col", rsp_payload.row_of_col, want.row_of_col);
            if (rsp_payload.last_out !== want.last_out)
               report_mismatch("last_out", rsp_payload.last_out, want.last_out);
         end
      end
   end

   // Receiver: a long hold-off when asked, otherwise a stall pattern of its own.
   always @(negedge clock) begin
      cycle_count++;
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_ready <= 1'b0;
      end else if ((cycle_count / 64) % 3 == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      size_reg = SIZE_RESET;
      error_count = 0;
      beats_sent = 0;
      solves_run = 0;
      results_seen = 0;
      cycle_count = 0;
      hold_off_cycles = 0;
      burst_on = 1'b0;
      burst_left = 0;
      for (int i = 0; i < 256; i++) cost_mirror[i] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_size();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (50) @(negedge clock);
      $display("Covered %0d entry beats, %0d solves, %0d result beats; sizes 0 to 31.",
               beats_sent, solves_run, results_seen);
      if (error_count == 0 && expected_assignments.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/mcas_pkg.sv
hw/rtl/mcas_cost_mem.sv
hw/rtl/mcas_engine.sv
hw/rtl/min_cost_assignment_solver_core.sv
verif/tb.sv
